// ===== rtl/rpf_pkg.sv =====
// Shared types, constants and helper functions for the RGB PWM color fader.
package rpf_pkg;

    localparam int unsigned SLOT_W   = 8;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned FRAMES_W = 16;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [DUTY_W-1:0]   t_duty;
    typedef logic [FRAMES_W-1:0] t_frames;
    typedef logic [PHASE_W-1:0]  t_phase;

    localparam t_phase  PHASE_HOLD = 3'd7;
    localparam t_slot   FIRST_SLOT = 8'd1;

    localparam t_frames RST_FRAMES_PER_STEP = 16'd8;
    localparam t_frames RST_HOLD_FRAMES     = 16'd1000;
    localparam t_duty   RST_PEAK_LEVEL      = 8'd120;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAMES_PER_STEP = 2'd0,
        CFG_HOLD_FRAMES     = 2'd1,
        CFG_PEAK_LEVEL      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_phase phase;
        t_duty  red;
        t_duty  green;
        t_duty  blue;
    } t_fade;

    typedef struct packed {
        logic   red_on;
        logic   green_on;
        logic   blue_on;
        t_phase phase_now;
        t_duty  red_level;
        t_duty  green_level;
        t_duty  blue_level;
    } t_result;

    // Lit channels per fade phase: bit 2 red, bit 1 green, bit 0 blue.
    function automatic logic [2:0] lit_mask(input t_phase ph);
        logic [2:0] m;
        case (ph)
            3'd0:    m = 3'b010;
            3'd1:    m = 3'b011;
            3'd2:    m = 3'b001;
            3'd3:    m = 3'b101;
            3'd4:    m = 3'b100;
            3'd5:    m = 3'b110;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

    function automatic t_duty move_toward(input t_duty d, input t_duty t);
        t_duty r;
        if (d < t) begin
            r = d + 8'd1;
        end else if (d > t) begin
            r = d - 8'd1;
        end else begin
            r = d;
        end
        return r;
    endfunction

    function automatic t_frames at_least_one(input t_frames f);
        return (f == '0) ? 16'd1 : f;
    endfunction

endpackage

// ===== rtl/rgb_pwm_color_fader_core.sv =====
// Top level of the RGB PWM color fader: slot counter, sequencer state and configuration.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_advance): one transfer per PWM slot.
//   With i_advance high the slot counter moves on; with it low all state holds
//   and the result repeats the current slot.
//   Output channel (o_out_valid / i_out_ready): one result per input transfer,
//   carrying the three LED enables, the phase and the three duty levels.
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
//   always ready; index 0 frames per step, 1 hold frames, 2 peak level;
//   other indexes are dropped. Write only while the block is idle.
// Latency and throughput:
//   A result appears in the cycle after its input transfer. One item per cycle is
//   sustained while i_out_ready stays high; the fade step, two short stages that
//   resolve any reached phase directly, is combinational ahead of the result register.
// Reset:
//   Phase 0, all duties 0, slot 1, a fade step due at the next frame start,
//   registers at 8, 1000 and 120. No result is pending.
// Stall:
//   While the receiver holds i_out_ready low with a result pending, o_in_ready
//   drops and the result holds until it is taken.
module rgb_pwm_color_fader_core #(
    parameter int unsigned FRAME_SLOTS = 254
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_advance,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_red_on,
    output logic                               o_green_on,
    output logic                               o_blue_on,
    output logic [rpf_pkg::PHASE_W-1:0]        o_phase_now,
    output logic [rpf_pkg::DUTY_W-1:0]         o_red_level,
    output logic [rpf_pkg::DUTY_W-1:0]         o_green_level,
    output logic [rpf_pkg::DUTY_W-1:0]         o_blue_level,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rpf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam rpf_pkg::t_slot LAST_SLOT = rpf_pkg::t_slot'(FRAME_SLOTS);

    rpf_pkg::t_frames r_frames_per_step;
    rpf_pkg::t_frames r_hold_frames;
    rpf_pkg::t_duty   r_peak_level;

    rpf_pkg::t_fade   r_fade;
    rpf_pkg::t_slot   r_slot;
    rpf_pkg::t_frames r_frames_left;

    rpf_pkg::t_fade   n_fade;
    rpf_pkg::t_slot   n_slot;
    rpf_pkg::t_frames n_frames_left;

    rpf_pkg::t_fade   step_fade;
    rpf_pkg::t_frames step_frames;
    rpf_pkg::t_result res;
    rpf_pkg::t_result out_data;

    logic in_accept;
    logic do_step;
    logic frame_end;
    logic dark;
    logic out_space;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = out_space;
    assign in_accept   = i_in_valid && out_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_per_step <= rpf_pkg::RST_FRAMES_PER_STEP;
            r_hold_frames     <= rpf_pkg::RST_HOLD_FRAMES;
            r_peak_level      <= rpf_pkg::RST_PEAK_LEVEL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rpf_pkg::CFG_FRAMES_PER_STEP: r_frames_per_step <= i_cfg_data;
                rpf_pkg::CFG_HOLD_FRAMES:     r_hold_frames     <= i_cfg_data;
                rpf_pkg::CFG_PEAK_LEVEL:      r_peak_level      <= i_cfg_data[rpf_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    rpf_fade_step u_fade_step (
        .i_cur             (r_fade),
        .i_frames_per_step (r_frames_per_step),
        .i_hold_frames     (r_hold_frames),
        .i_peak_level      (r_peak_level),
        .o_next            (step_fade),
        .o_frames_left     (step_frames)
    );

    always_comb begin
        rpf_pkg::t_frames base_left;

        do_step   = i_advance && (r_slot == rpf_pkg::FIRST_SLOT) && (r_frames_left == '0);
        frame_end = r_slot >= LAST_SLOT;
        n_fade    = do_step ? step_fade : r_fade;
        base_left = do_step ? step_frames : r_frames_left;

        n_slot        = r_slot;
        n_frames_left = base_left;
        if (i_advance) begin
            if (frame_end) begin
                n_slot = rpf_pkg::FIRST_SLOT;
                if (base_left != '0) begin
                    n_frames_left = base_left - 16'd1;
                end
            end else begin
                n_slot = r_slot + 8'd1;
            end
        end

        dark             = n_fade.phase == rpf_pkg::PHASE_HOLD;
        res.red_on       = !dark && (r_slot < n_fade.red);
        res.green_on     = !dark && (r_slot < n_fade.green);
        res.blue_on      = !dark && (r_slot < n_fade.blue);
        res.phase_now    = n_fade.phase;
        res.red_level    = n_fade.red;
        res.green_level  = n_fade.green;
        res.blue_level   = n_fade.blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade        <= '0;
            r_slot        <= rpf_pkg::FIRST_SLOT;
            r_frames_left <= '0;
        end else if (in_accept) begin
            r_fade        <= n_fade;
            r_slot        <= n_slot;
            r_frames_left <= n_frames_left;
        end
    end

    rpf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_accept),
        .i_data  (res),
        .o_space (out_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_red_on      = out_data.red_on;
    assign o_green_on    = out_data.green_on;
    assign o_blue_on     = out_data.blue_on;
    assign o_phase_now   = out_data.phase_now;
    assign o_red_level   = out_data.red_level;
    assign o_green_level = out_data.green_level;
    assign o_blue_level  = out_data.blue_level;

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot != '0) && (r_slot <= LAST_SLOT))
        else $error("slot counter out of frame range");

    a_hold_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_advance |=> $stable(r_slot) && $stable(r_fade)
            && $stable(r_frames_left))
        else $error("state moved on a hold transfer");

    a_step_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && do_step |=> r_frames_left != '0)
        else $error("fade step left no frames to show");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_advance && frame_end |=> r_slot == rpf_pkg::FIRST_SLOT)
        else $error("slot counter did not wrap at frame end");
`endif

endmodule

// ===== rtl/rpf_fade_step.sv =====
// Fade sequencer step: moves duties toward phase targets, skipping phases already reached.
module rpf_fade_step (
    input  rpf_pkg::t_fade   i_cur,
    input  rpf_pkg::t_frames i_frames_per_step,
    input  rpf_pkg::t_frames i_hold_frames,
    input  rpf_pkg::t_duty   i_peak_level,
    output rpf_pkg::t_fade   o_next,
    output rpf_pkg::t_frames o_frames_left
);

    always_comb begin
        rpf_pkg::t_phase  ph_a;
        rpf_pkg::t_phase  ph_b;
        logic [2:0]       m_a;
        logic [2:0]       m_b;
        rpf_pkg::t_duty   tr_a;
        rpf_pkg::t_duty   tg_a;
        rpf_pkg::t_duty   tb_a;
        rpf_pkg::t_duty   dr_a;
        rpf_pkg::t_duty   dg_a;
        rpf_pkg::t_duty   db_a;
        rpf_pkg::t_duty   tr_b;
        rpf_pkg::t_duty   tg_b;
        rpf_pkg::t_duty   tb_b;
        rpf_pkg::t_duty   dr_b;
        rpf_pkg::t_duty   dg_b;
        rpf_pkg::t_duty   db_b;
        logic             hit_a;
        logic             flat;

        ph_a  = (i_cur.phase == rpf_pkg::PHASE_HOLD) ? '0 : i_cur.phase;
        m_a   = rpf_pkg::lit_mask(ph_a);
        tr_a  = m_a[2] ? i_peak_level : '0;
        tg_a  = m_a[1] ? i_peak_level : '0;
        tb_a  = m_a[0] ? i_peak_level : '0;
        dr_a  = rpf_pkg::move_toward(i_cur.red, tr_a);
        dg_a  = rpf_pkg::move_toward(i_cur.green, tg_a);
        db_a  = rpf_pkg::move_toward(i_cur.blue, tb_a);
        hit_a = (dr_a == tr_a) && (dg_a == tg_a) && (db_a == tb_a);

        ph_b  = ph_a + 3'd1;
        m_b   = rpf_pkg::lit_mask(ph_b);
        tr_b  = m_b[2] ? i_peak_level : '0;
        tg_b  = m_b[1] ? i_peak_level : '0;
        tb_b  = m_b[0] ? i_peak_level : '0;
        dr_b  = rpf_pkg::move_toward(tr_a, tr_b);
        dg_b  = rpf_pkg::move_toward(tg_a, tg_b);
        db_b  = rpf_pkg::move_toward(tb_a, tb_b);
        // Peak of 0 or 1: every later phase is reached in one step, run on to the dark hold.
        flat  = (i_peak_level[rpf_pkg::DUTY_W-1:1] == '0);

        o_next.phase  = ph_a;
        o_next.red    = dr_a;
        o_next.green  = dg_a;
        o_next.blue   = db_a;
        o_frames_left = rpf_pkg::at_least_one(i_frames_per_step);
        if (hit_a) begin
            if ((ph_b == rpf_pkg::PHASE_HOLD) || flat) begin
                o_next.phase  = rpf_pkg::PHASE_HOLD;
                o_next.red    = '0;
                o_next.green  = '0;
                o_next.blue   = '0;
                o_frames_left = rpf_pkg::at_least_one(i_hold_frames);
            end else begin
                o_next.phase  = ph_b;
                o_next.red    = dr_b;
                o_next.green  = dg_b;
                o_next.blue   = db_b;
            end
        end
    end

endmodule

// ===== rtl/rpf_out_reg.sv =====
// Output result register with valid/ready handshake toward the receiver.
module rpf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rpf_pkg::t_result i_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output rpf_pkg::t_result o_data
);

    logic             r_valid;
    rpf_pkg::t_result r_data;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule
